/* design/ypem_pkg.sv */
// ----------------------------------------------------------------------------
// ypem_pkg
// Shared constants, codes and the work item type of the YUV plane error
// metrics block.
// ----------------------------------------------------------------------------
`default_nettype none

package ypem_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_DIM_DEF    = 8192;
  localparam int COUNT_BITS_DEF = 40;

  // Fixed field and store widths.
  localparam int CFG_BITS    = 14;
  localparam int BYTE_BITS   = 8;
  localparam int BIN_BITS    = 8;
  localparam int HIST_BINS   = 256;
  localparam int ABS_BITS    = 48;
  localparam int SQ_BITS     = 56;
  localparam int SQ_IN_BITS  = 16;
  localparam int SET_BITS    = 2;
  localparam int NUM_SETS    = 4;
  localparam int ACTION_BITS = 2;

  // Queue depths.
  localparam int WORK_DEPTH   = 4;
  localparam int RESULT_DEPTH = 2;

  // Register file.
  localparam int PADDR_BITS    = 4;
  localparam int APB_DATA_BITS = 32;
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHROMA_ABSENT = 2'd2;
  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 14'd1920;
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 14'd1080;

  // Request actions.
  localparam logic [ACTION_BITS-1:0] ACT_ACCUM = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd2;

  // Statistic sets.
  localparam logic [SET_BITS-1:0] PLANE_Y = 2'd0;
  localparam logic [SET_BITS-1:0] PLANE_U = 2'd1;
  localparam logic [SET_BITS-1:0] PLANE_V = 2'd2;
  localparam logic [SET_BITS-1:0] SET_ALL = 2'd3;

  // One classified request. For an accumulate, bin carries the absolute
  // error and set the plane; for a read they carry the requested bin and set.
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [SET_BITS-1:0]    set;
    logic [BIN_BITS-1:0]    bin;
    logic [SQ_IN_BITS-1:0]  sq;
  } work_t;

endpackage

`default_nettype wire

/* design/ypem_queue.sv */
// ----------------------------------------------------------------------------
// ypem_queue
// Small register FIFO with full and empty flags; DEPTH is a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module ypem_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slot_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

/* design/ypem_front.sv */
// ----------------------------------------------------------------------------
// ypem_front
// Takes requests, tracks the frame position, assigns each byte to its plane
// and computes the absolute and squared error before queueing the request.
// ----------------------------------------------------------------------------
`default_nettype none

module ypem_front #(
  parameter int MAX_DIM = ypem_pkg::MAX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ypem_pkg::CFG_BITS-1:0]      frame_width,
  input  logic [ypem_pkg::CFG_BITS-1:0]      frame_height,
  input  logic                               chroma_absent,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic [ypem_pkg::ACTION_BITS-1:0]   in_action,
  input  logic [ypem_pkg::BYTE_BITS-1:0]     in_ref_byte,
  input  logic [ypem_pkg::BYTE_BITS-1:0]     in_dist_byte,
  input  logic [ypem_pkg::SET_BITS-1:0]      in_plane_select,
  input  logic [ypem_pkg::BIN_BITS-1:0]      in_bin_index,
  output logic                               q_push,
  output ypem_pkg::work_t                    q_data,
  input  logic                               q_full
);

  localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
  localparam int CMP_BITS  = (DIM_BITS > ypem_pkg::CFG_BITS) ? DIM_BITS : ypem_pkg::CFG_BITS;
  localparam int PROD_BITS = 2 * DIM_BITS;
  localparam int POS_BITS  =
    $clog2(MAX_DIM * MAX_DIM + 2 * (MAX_DIM / 2) * (MAX_DIM / 2) + 1);

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [ypem_pkg::CFG_BITS-1:0] v);
    logic [CMP_BITS-1:0] ext;
    ext = CMP_BITS'(v);
    if (ext == '0) begin
      return DIM_BITS'(1);
    end else if (ext > CMP_BITS'(MAX_DIM)) begin
      return DIM_BITS'(MAX_DIM);
    end
    return DIM_BITS'(ext);
  endfunction

  // Plane boundaries, recomputed every cycle from the registers.
  logic [DIM_BITS-1:0]  w_c, h_c;
  logic [PROD_BITS-1:0] yprod_c, cprod_c;
  logic [POS_BITS-1:0]  ysize_c, csize_c, ycsize_c, fsize_c;
  logic [POS_BITS-1:0]  ysize_r, ycsize_r, fsize_r;

  // Input stage.
  logic                             f0_valid_r, f0_valid_nxt;
  logic [ypem_pkg::ACTION_BITS-1:0] f0_action_r;
  logic [ypem_pkg::BYTE_BITS-1:0]   f0_ref_r, f0_dist_r;
  logic [ypem_pkg::SET_BITS-1:0]    f0_sel_r;
  logic [ypem_pkg::BIN_BITS-1:0]    f0_bin_r;
  logic                             accept;

  // Classification.
  logic [POS_BITS-1:0]              pos_r, pos_nxt, pos_eff, pos_inc, pos_wrap;
  logic [ypem_pkg::BYTE_BITS-1:0]   err_c;
  logic [ypem_pkg::SQ_IN_BITS-1:0]  sq_c;
  logic [ypem_pkg::SET_BITS-1:0]    plane_c;

  always_comb begin
    w_c      = clamp_dim(frame_width);
    h_c      = clamp_dim(frame_height);
    yprod_c  = PROD_BITS'(w_c) * PROD_BITS'(h_c);
    cprod_c  = PROD_BITS'(w_c >> 1) * PROD_BITS'(h_c >> 1);
    ysize_c  = POS_BITS'(yprod_c);
    csize_c  = chroma_absent ? '0 : POS_BITS'(cprod_c);
    ycsize_c = ysize_c + csize_c;
    fsize_c  = ycsize_c + csize_c;
  end

  always_ff @(posedge clk) begin
    ysize_r  <= ysize_c;
    ycsize_r <= ycsize_c;
    fsize_r  <= fsize_c;
  end

  assign in_full = f0_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = f0_valid_r && !q_full;

  always_comb begin
    f0_valid_nxt = f0_valid_r;
    if (accept) begin
      f0_valid_nxt = 1'b1;
    end else if (q_push) begin
      f0_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    err_c    = (f0_ref_r >= f0_dist_r) ? f0_ref_r - f0_dist_r : f0_dist_r - f0_ref_r;
    sq_c     = ypem_pkg::SQ_IN_BITS'(err_c) * ypem_pkg::SQ_IN_BITS'(err_c);
    // A position left beyond the frame by a size change restarts the frame.
    pos_eff  = (pos_r >= fsize_r) ? '0 : pos_r;
    pos_inc  = pos_eff + 1'b1;
    pos_wrap = (pos_inc >= fsize_r) ? '0 : pos_inc;
    if (pos_eff < ysize_r) begin
      plane_c = ypem_pkg::PLANE_Y;
    end else if (pos_eff < ycsize_r) begin
      plane_c = ypem_pkg::PLANE_U;
    end else begin
      plane_c = ypem_pkg::PLANE_V;
    end
  end

  always_comb begin
    q_data        = '0;
    q_data.action = f0_action_r;
    pos_nxt       = pos_r;
    case (f0_action_r)
      ypem_pkg::ACT_ACCUM: begin
        q_data.set = plane_c;
        q_data.bin = err_c;
        q_data.sq  = sq_c;
        pos_nxt    = pos_wrap;
      end
      ypem_pkg::ACT_READ: begin
        q_data.set = f0_sel_r;
        q_data.bin = f0_bin_r;
      end
      ypem_pkg::ACT_CLEAR: begin
        pos_nxt = '0;
      end
      default: begin
        q_data.action = f0_action_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_valid_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      f0_valid_r <= f0_valid_nxt;
      if (q_push) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f0_action_r <= in_action;
      f0_ref_r    <= in_ref_byte;
      f0_dist_r   <= in_dist_byte;
      f0_sel_r    <= in_plane_select;
      f0_bin_r    <= in_bin_index;
    end
  end

endmodule

`default_nettype wire

/* design/ypem_back.sv */
// ----------------------------------------------------------------------------
// ypem_back
// Carries out queued requests: per-set accumulators, the histogram memory
// with read-modify-write forwarding, the clearing sweep and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ypem_back #(
  parameter int COUNT_BITS = ypem_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ypem_pkg::work_t                 q_data,
  input  logic                            q_empty,
  output logic                            q_pop,
  output logic                            init_busy,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic [ypem_pkg::SET_BITS-1:0]   out_sample_plane,
  output logic [ypem_pkg::BYTE_BITS-1:0]  out_abs_error,
  output logic [COUNT_BITS-1:0]           out_sample_count,
  output logic [COUNT_BITS-1:0]           out_differing_count,
  output logic [ypem_pkg::BYTE_BITS-1:0]  out_largest_error,
  output logic [ypem_pkg::ABS_BITS-1:0]   out_abs_error_total,
  output logic [ypem_pkg::SQ_BITS-1:0]    out_sq_error_total,
  output logic [COUNT_BITS-1:0]           out_bin_count
);

  localparam int NSETS    = ypem_pkg::NUM_SETS;
  localparam int ABS_W    = ypem_pkg::ABS_BITS;
  localparam int SQ_W     = ypem_pkg::SQ_BITS;
  localparam int ROW_BITS = NSETS * COUNT_BITS;
  localparam int RES_BITS = ypem_pkg::SET_BITS + 2 * ypem_pkg::BYTE_BITS + 3 * COUNT_BITS
                            + ABS_W + SQ_W;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Histogram rows: one row per bin, one lane per set.
  logic [ROW_BITS-1:0] hist_mem [ypem_pkg::HIST_BINS];

  logic                           s2_valid_r;
  ypem_pkg::work_t                s2_work_r;
  logic [ROW_BITS-1:0]            mem_q_r;
  logic                           fwd_valid_r;
  logic [ypem_pkg::BIN_BITS-1:0]  fwd_addr_r;
  logic [ROW_BITS-1:0]            fwd_row_r;
  logic                           sweep_r, sweep_nxt;
  logic                           init_r, init_nxt;
  logic [ypem_pkg::BIN_BITS-1:0]  sweep_cnt_r, sweep_cnt_nxt;

  logic [COUNT_BITS-1:0]          cnt_r  [NSETS];
  logic [COUNT_BITS-1:0]          cnt_nxt [NSETS];
  logic [COUNT_BITS-1:0]          diff_r [NSETS];
  logic [COUNT_BITS-1:0]          diff_nxt [NSETS];
  logic [ypem_pkg::BYTE_BITS-1:0] max_r  [NSETS];
  logic [ypem_pkg::BYTE_BITS-1:0] max_nxt [NSETS];
  logic [ABS_W-1:0]               abs_r  [NSETS];
  logic [ABS_W-1:0]               abs_nxt [NSETS];
  logic [SQ_W-1:0]                sq_r   [NSETS];
  logic [SQ_W-1:0]                sq_nxt [NSETS];
  logic [ABS_W:0]                 abs_sum_c [NSETS];
  logic [SQ_W:0]                  sq_sum_c  [NSETS];
  logic [NSETS-1:0]               hit_c;

  logic                           s2_fire, s2_accum, s2_clear, s1_load;
  logic [ROW_BITS-1:0]            row_cur, row_new;
  logic                           wr_en;
  logic [ypem_pkg::BIN_BITS-1:0]  wr_addr;
  logic [ROW_BITS-1:0]            wr_row;
  logic                           oq_full;
  logic [RES_BITS-1:0]            oq_din, oq_dout;

  logic [ypem_pkg::SET_BITS-1:0]  res_plane;
  logic [ypem_pkg::BYTE_BITS-1:0] res_abs, res_max;
  logic [COUNT_BITS-1:0]          res_cnt, res_diff, res_bin;
  logic [ABS_W-1:0]               res_abst;
  logic [SQ_W-1:0]                res_sq;

  assign s2_accum  = (s2_work_r.action == ypem_pkg::ACT_ACCUM);
  assign s2_clear  = (s2_work_r.action == ypem_pkg::ACT_CLEAR);
  assign s2_fire   = s2_valid_r && !oq_full;
  // A clear holds the issue stage so that nothing reads the histogram
  // before the sweep has emptied it.
  assign s1_load   = !q_empty && !sweep_r && (!s2_valid_r || s2_fire)
                     && !(s2_valid_r && s2_clear);
  assign q_pop     = s1_load;
  assign init_busy = init_r;

  // The row written at the edge of this row's read is newer than the memory.
  assign row_cur = (fwd_valid_r && (fwd_addr_r == s2_work_r.bin)) ? fwd_row_r : mem_q_r;

  always_comb begin
    for (int i = 0; i < NSETS; i++) begin
      hit_c[i] = s2_accum && ((s2_work_r.set == ypem_pkg::SET_BITS'(i))
                              || (ypem_pkg::SET_BITS'(i) == ypem_pkg::SET_ALL));
      row_new[i*COUNT_BITS +: COUNT_BITS] = hit_c[i]
        ? sat_inc(row_cur[i*COUNT_BITS +: COUNT_BITS])
        : row_cur[i*COUNT_BITS +: COUNT_BITS];
    end
  end

  always_comb begin
    wr_en   = sweep_r || (s2_fire && s2_accum);
    wr_addr = sweep_r ? sweep_cnt_r : s2_work_r.bin;
    wr_row  = sweep_r ? '0 : row_new;
  end

  always_comb begin
    for (int i = 0; i < NSETS; i++) begin
      abs_sum_c[i] = {1'b0, abs_r[i]} + (ABS_W + 1)'(s2_work_r.bin);
      sq_sum_c[i]  = {1'b0, sq_r[i]} + (SQ_W + 1)'(s2_work_r.sq);
      cnt_nxt[i]   = cnt_r[i];
      diff_nxt[i]  = diff_r[i];
      max_nxt[i]   = max_r[i];
      abs_nxt[i]   = abs_r[i];
      sq_nxt[i]    = sq_r[i];
      if (s2_fire && s2_clear) begin
        cnt_nxt[i]  = '0;
        diff_nxt[i] = '0;
        max_nxt[i]  = '0;
        abs_nxt[i]  = '0;
        sq_nxt[i]   = '0;
      end else if (s2_fire && hit_c[i]) begin
        cnt_nxt[i]  = sat_inc(cnt_r[i]);
        diff_nxt[i] = (s2_work_r.bin != '0) ? sat_inc(diff_r[i]) : diff_r[i];
        max_nxt[i]  = (s2_work_r.bin > max_r[i]) ? s2_work_r.bin : max_r[i];
        abs_nxt[i]  = abs_sum_c[i][ABS_W] ? '1 : abs_sum_c[i][ABS_W-1:0];
        sq_nxt[i]   = sq_sum_c[i][SQ_W] ? '1 : sq_sum_c[i][SQ_W-1:0];
      end
    end
  end

  always_comb begin
    sweep_nxt     = sweep_r;
    init_nxt      = init_r;
    sweep_cnt_nxt = sweep_cnt_r;
    if (sweep_r) begin
      sweep_cnt_nxt = sweep_cnt_r + 1'b1;
      if (sweep_cnt_r == ypem_pkg::BIN_BITS'(ypem_pkg::HIST_BINS - 1)) begin
        sweep_nxt = 1'b0;
        init_nxt  = 1'b0;
      end
    end else if (s2_fire && s2_clear) begin
      sweep_nxt     = 1'b1;
      sweep_cnt_nxt = '0;
    end
  end

  always_comb begin
    res_plane = '0;
    res_abs   = '0;
    res_cnt   = '0;
    res_diff  = '0;
    res_max   = '0;
    res_abst  = '0;
    res_sq    = '0;
    res_bin   = '0;
    case (s2_work_r.action)
      ypem_pkg::ACT_ACCUM: begin
        res_plane = s2_work_r.set;
        res_abs   = s2_work_r.bin;
      end
      ypem_pkg::ACT_READ: begin
        res_plane = s2_work_r.set;
        res_cnt   = cnt_r[s2_work_r.set];
        res_diff  = diff_r[s2_work_r.set];
        res_max   = max_r[s2_work_r.set];
        res_abst  = abs_r[s2_work_r.set];
        res_sq    = sq_r[s2_work_r.set];
        res_bin   = row_cur[s2_work_r.set * COUNT_BITS +: COUNT_BITS];
      end
      default: begin
        res_plane = '0;
      end
    endcase
  end

  assign oq_din = {res_plane, res_abs, res_cnt, res_diff, res_max, res_abst, res_sq, res_bin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      sweep_r     <= 1'b1;
      init_r      <= 1'b1;
      sweep_cnt_r <= '0;
      for (int i = 0; i < NSETS; i++) begin
        cnt_r[i]  <= '0;
        diff_r[i] <= '0;
        max_r[i]  <= '0;
        abs_r[i]  <= '0;
        sq_r[i]   <= '0;
      end
    end else begin
      if (s1_load) begin
        s2_valid_r <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_r <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
      sweep_r     <= sweep_nxt;
      init_r      <= init_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      for (int i = 0; i < NSETS; i++) begin
        cnt_r[i]  <= cnt_nxt[i];
        diff_r[i] <= diff_nxt[i];
        max_r[i]  <= max_nxt[i];
        abs_r[i]  <= abs_nxt[i];
        sq_r[i]   <= sq_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_row;
      fwd_addr_r        <= wr_addr;
      fwd_row_r         <= wr_row;
    end
    if (s1_load) begin
      mem_q_r   <= hist_mem[q_data.bin];
      s2_work_r <= q_data;
    end
  end

  ypem_queue #(
    .WIDTH (RES_BITS),
    .DEPTH (ypem_pkg::RESULT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s2_fire),
    .din   (oq_din),
    .full  (oq_full),
    .pop   (out_pop),
    .dout  (oq_dout),
    .empty (out_empty)
  );

  assign {out_sample_plane, out_abs_error, out_sample_count, out_differing_count,
          out_largest_error, out_abs_error_total, out_sq_error_total, out_bin_count} = oq_dout;

endmodule

`default_nettype wire

/* design/yuv_plane_error_metrics_core.sv */
// ----------------------------------------------------------------------------
// yuv_plane_error_metrics_core
// A result passes the input register, work queue, issue register and result
// queue. One request per cycle unless a sweep runs or results back up, set by
// the histogram read-modify-write loop, which forwards the row written in the
// previous cycle. A clear stalls the back end for a 256-row histogram sweep.
// Reset is synchronous, active low; full stays high until its sweep ends.
// ----------------------------------------------------------------------------
`default_nettype none

// The block compares co-located reference and distorted bytes of planar
// YUV 4:2:0 or luma-only frames. Requests come in through a queue-style
// port (push/full) and each one produces exactly one result on a queue-style
// output (empty/pop).
//
// The front end registers each request, assigns accumulate bytes to the Y, U
// or V plane from a running frame position, and computes the absolute and
// squared error. Plane boundaries are derived from the width and height
// registers every cycle, so a register write is in effect for the very next
// request. Classified requests go through a four-entry queue to the back end.
//
// The back end keeps saturating statistics per set (Y, U, V and all planes)
// in flip-flops and the 256-bin error histograms in a memory with one row
// per bin and one lane per set, so an accumulate touches a single row. The
// row is read when a request is issued and written when it completes; a row
// written in the same cycle as a read is forwarded. Results leave through a
// two-entry output queue, so the input side keeps taking requests while a
// result waits to be popped.
//
// A clear request empties all statistics and then sweeps the histogram
// memory one row per cycle; requests queue up meanwhile. The same sweep runs
// after reset, and during it full is held high.
module yuv_plane_error_metrics_core #(
  parameter int MAX_DIM    = ypem_pkg::MAX_DIM_DEF,
  parameter int COUNT_BITS = ypem_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Request side.
  input  logic                                  push,
  output logic                                  full,
  input  logic [ypem_pkg::ACTION_BITS-1:0]      in_action,
  input  logic [ypem_pkg::BYTE_BITS-1:0]        in_ref_byte,
  input  logic [ypem_pkg::BYTE_BITS-1:0]        in_dist_byte,
  input  logic [ypem_pkg::SET_BITS-1:0]         in_plane_select,
  input  logic [ypem_pkg::BIN_BITS-1:0]         in_bin_index,
  // Result side.
  output logic                                  empty,
  input  logic                                  pop,
  output logic [ypem_pkg::SET_BITS-1:0]         out_sample_plane,
  output logic [ypem_pkg::BYTE_BITS-1:0]        out_abs_error,
  output logic [COUNT_BITS-1:0]                 out_sample_count,
  output logic [COUNT_BITS-1:0]                 out_differing_count,
  output logic [ypem_pkg::BYTE_BITS-1:0]        out_largest_error,
  output logic [ypem_pkg::ABS_BITS-1:0]         out_abs_error_total,
  output logic [ypem_pkg::SQ_BITS-1:0]          out_sq_error_total,
  output logic [COUNT_BITS-1:0]                 out_bin_count,
  // Register port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ypem_pkg::PADDR_BITS-1:0]       paddr,
  input  logic [ypem_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [ypem_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);

  localparam int WORK_BITS = $bits(ypem_pkg::work_t);

  // Configuration registers.
  logic [ypem_pkg::CFG_BITS-1:0] frame_width_r, frame_width_nxt;
  logic [ypem_pkg::CFG_BITS-1:0] frame_height_r, frame_height_nxt;
  logic                          chroma_absent_r, chroma_absent_nxt;
  logic                          reg_wr;
  logic [1:0]                    reg_idx;

  // Interconnect between the front end, the work queue and the back end.
  logic                  front_push, front_full;
  logic                  init_busy;
  logic                  wq_push, wq_full, wq_pop, wq_empty;
  ypem_pkg::work_t       wq_din, wq_head;
  logic [WORK_BITS-1:0]  wq_dout;

  // The register port never waits; a write lands at the end of its access
  // cycle. Byte address bits below the word are ignored.
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ypem_pkg::PADDR_BITS-1:2];

  always_comb begin
    frame_width_nxt   = frame_width_r;
    frame_height_nxt  = frame_height_r;
    chroma_absent_nxt = chroma_absent_r;
    if (reg_wr) begin
      case (reg_idx)
        ypem_pkg::REG_FRAME_WIDTH:   frame_width_nxt   = pwdata[ypem_pkg::CFG_BITS-1:0];
        ypem_pkg::REG_FRAME_HEIGHT:  frame_height_nxt  = pwdata[ypem_pkg::CFG_BITS-1:0];
        ypem_pkg::REG_CHROMA_ABSENT: chroma_absent_nxt = pwdata[0];
        default:                     frame_width_nxt   = frame_width_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ypem_pkg::REG_FRAME_WIDTH:   prdata = ypem_pkg::APB_DATA_BITS'(frame_width_r);
      ypem_pkg::REG_FRAME_HEIGHT:  prdata = ypem_pkg::APB_DATA_BITS'(frame_height_r);
      ypem_pkg::REG_CHROMA_ABSENT: prdata = ypem_pkg::APB_DATA_BITS'(chroma_absent_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= ypem_pkg::FRAME_WIDTH_RST;
      frame_height_r  <= ypem_pkg::FRAME_HEIGHT_RST;
      chroma_absent_r <= 1'b0;
    end else begin
      frame_width_r   <= frame_width_nxt;
      frame_height_r  <= frame_height_nxt;
      chroma_absent_r <= chroma_absent_nxt;
    end
  end

  // No request enters while the histogram is being swept after reset.
  assign full       = front_full || init_busy;
  assign front_push = push && !init_busy;

  ypem_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .frame_width     (frame_width_r),
    .frame_height    (frame_height_r),
    .chroma_absent   (chroma_absent_r),
    .in_push         (front_push),
    .in_full         (front_full),
    .in_action       (in_action),
    .in_ref_byte     (in_ref_byte),
    .in_dist_byte    (in_dist_byte),
    .in_plane_select (in_plane_select),
    .in_bin_index    (in_bin_index),
    .q_push          (wq_push),
    .q_data          (wq_din),
    .q_full          (wq_full)
  );

  ypem_queue #(
    .WIDTH (WORK_BITS),
    .DEPTH (ypem_pkg::WORK_DEPTH)
  ) u_work_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (wq_push),
    .din   (wq_din),
    .full  (wq_full),
    .pop   (wq_pop),
    .dout  (wq_dout),
    .empty (wq_empty)
  );

  assign wq_head = wq_dout;

  ypem_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_data              (wq_head),
    .q_empty             (wq_empty),
    .q_pop               (wq_pop),
    .init_busy           (init_busy),
    .out_pop             (pop),
    .out_empty           (empty),
    .out_sample_plane    (out_sample_plane),
    .out_abs_error       (out_abs_error),
    .out_sample_count    (out_sample_count),
    .out_differing_count (out_differing_count),
    .out_largest_error   (out_largest_error),
    .out_abs_error_total (out_abs_error_total),
    .out_sq_error_total  (out_sq_error_total),
    .out_bin_count       (out_bin_count)
  );

endmodule

`default_nettype wire

/* test/plane_stats_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_stats_check_pkg
// Request and result types for the YUV plane error metrics testbench, and a
// tracker class. The tracker mirrors the block's frame position and
// per-plane statistics, and it checks each result against the oldest
// expectation.
// ----------------------------------------------------------------------------
package plane_stats_check_pkg;
  import ypem_pkg::*;

  // The block ignores this action code. It changes no state and returns zeros.
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

  localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_BITS_DEF) - 64'd1;
  localparam longint unsigned ABS_LIMIT   = (64'd1 << ABS_BITS) - 64'd1;
  localparam longint unsigned SQ_LIMIT    = (64'd1 << SQ_BITS) - 64'd1;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [BYTE_BITS-1:0]   ref_byte;
    logic [BYTE_BITS-1:0]   dist_byte;
    logic [SET_BITS-1:0]    plane_select;
    logic [BIN_BITS-1:0]    bin_index;
  } stats_req_t;

  typedef struct packed {
    logic [SET_BITS-1:0]       sample_plane;
    logic [BYTE_BITS-1:0]      abs_error;
    logic [COUNT_BITS_DEF-1:0] sample_count;
    logic [COUNT_BITS_DEF-1:0] differing_count;
    logic [BYTE_BITS-1:0]      largest_error;
    logic [ABS_BITS-1:0]       abs_error_total;
    logic [SQ_BITS-1:0]        sq_error_total;
    logic [COUNT_BITS_DEF-1:0] bin_count;
  } metrics_t;

  class plane_error_tracker;
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic                chroma_off;
    longint unsigned     position;
    longint unsigned     sample_cnt[NUM_SETS];
    longint unsigned     diff_cnt[NUM_SETS];
    longint unsigned     peak_err[NUM_SETS];
    longint unsigned     abs_sum[NUM_SETS];
    longint unsigned     sq_sum[NUM_SETS];
    longint unsigned     hist[NUM_SETS][HIST_BINS];
    metrics_t            expected_metrics[$];
    int                  fail_count;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      chroma_off = 1'b0;
      fail_count = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      position = 0;
      foreach (sample_cnt[s]) begin
        sample_cnt[s] = 0;
        diff_cnt[s]   = 0;
        peak_err[s]   = 0;
        abs_sum[s]    = 0;
        sq_sum[s]     = 0;
      end
      foreach (hist[s, b]) hist[s][b] = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_FRAME_WIDTH:   width_reg  = value[CFG_BITS-1:0];
        REG_FRAME_HEIGHT:  height_reg = value[CFG_BITS-1:0];
        REG_CHROMA_ABSENT: chroma_off = value[0];
        default: ;
      endcase
    endfunction

    function longint unsigned clamp_dim(longint unsigned v);
      if (v == 0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return v;
    endfunction

    function longint unsigned sat_add(longint unsigned acc, longint unsigned inc,
                                      longint unsigned limit);
      if (acc >= limit || inc > limit - acc) return limit;
      return acc + inc;
    endfunction

    function void add_sample(logic [SET_BITS-1:0] s, longint unsigned err);
      sample_cnt[s] = sat_add(sample_cnt[s], 64'd1, COUNT_LIMIT);
      if (err != 0) diff_cnt[s] = sat_add(diff_cnt[s], 64'd1, COUNT_LIMIT);
      if (err > peak_err[s]) peak_err[s] = err;
      abs_sum[s] = sat_add(abs_sum[s], err, ABS_LIMIT);
      sq_sum[s]  = sat_add(sq_sum[s], err * err, SQ_LIMIT);
      hist[s][err % HIST_BINS] = sat_add(hist[s][err % HIST_BINS], 64'd1, COUNT_LIMIT);
    endfunction

    function void note_request(stats_req_t r);
      metrics_t            want;
      longint unsigned     w, h, luma, chroma, frame, err;
      logic [SET_BITS-1:0] plane;
      want = '0;
      case (r.action)
        ACT_ACCUM: begin
          w      = clamp_dim(64'(width_reg));
          h      = clamp_dim(64'(height_reg));
          luma   = w * h;
          chroma = chroma_off ? 0 : (w / 2) * (h / 2);
          frame  = luma + 2 * chroma;
          err    = (r.ref_byte >= r.dist_byte) ? 64'(r.ref_byte - r.dist_byte)
                                               : 64'(r.dist_byte - r.ref_byte);
          if (position >= frame) position = 0;
          if (position < luma) plane = PLANE_Y;
          else if (position < luma + chroma) plane = PLANE_U;
          else plane = PLANE_V;
          add_sample(plane, err);
          add_sample(SET_ALL, err);
          position++;
          if (position >= frame) position = 0;
          want.sample_plane = plane;
          want.abs_error    = 8'(err);
        end
        ACT_READ: begin
          want.sample_plane    = r.plane_select;
          want.sample_count    = COUNT_BITS_DEF'(sample_cnt[r.plane_select]);
          want.differing_count = COUNT_BITS_DEF'(diff_cnt[r.plane_select]);
          want.largest_error   = BYTE_BITS'(peak_err[r.plane_select]);
          want.abs_error_total = ABS_BITS'(abs_sum[r.plane_select]);
          want.sq_error_total  = SQ_BITS'(sq_sum[r.plane_select]);
          want.bin_count       = COUNT_BITS_DEF'(hist[r.plane_select][r.bin_index]);
        end
        ACT_CLEAR: clear_stats();
        default: ;
      endcase
      expected_metrics.push_back(want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(metrics_t got);
      metrics_t want;
      if (expected_metrics.size() == 0) begin
        $error("result popped with no request outstanding");
        fail_count++;
        return;
      end
      want = expected_metrics.pop_front();
      compare_field("sample_plane", 64'(want.sample_plane), 64'(got.sample_plane));
      compare_field("abs_error", 64'(want.abs_error), 64'(got.abs_error));
      compare_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
      compare_field("differing_count", 64'(want.differing_count),
                    64'(got.differing_count));
      compare_field("largest_error", 64'(want.largest_error), 64'(got.largest_error));
      compare_field("abs_error_total", 64'(want.abs_error_total),
                    64'(got.abs_error_total));
      compare_field("sq_error_total", 64'(want.sq_error_total), 64'(got.sq_error_total));
      compare_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
    endfunction

    function int pending();
      return expected_metrics.size();
    endfunction
  endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for yuv_plane_error_metrics_core. A short directed
// sequence covers the byte extremes, every action and the frame boundary
// cases. Random traffic then runs under a series of frame geometries, with
// random gaps on both the request and the result side.
// ----------------------------------------------------------------------------
module tb;
  import ypem_pkg::*;
  import plane_stats_check_pkg::*;

  // Longest stretch without any accepted request or result. A correct run
  // stays far below this, even across a histogram sweep plus long gaps.
  localparam int WATCHDOG_LIMIT = 4000;

  logic                      clk             = 1'b0;
  logic                      rst_n           = 1'b0;
  logic                      push            = 1'b0;
  logic                      full;
  logic [ACTION_BITS-1:0]    in_action       = '0;
  logic [BYTE_BITS-1:0]      in_ref_byte     = '0;
  logic [BYTE_BITS-1:0]      in_dist_byte    = '0;
  logic [SET_BITS-1:0]       in_plane_select = '0;
  logic [BIN_BITS-1:0]       in_bin_index    = '0;
  logic                      empty;
  logic                      pop             = 1'b0;
  logic [SET_BITS-1:0]       out_sample_plane;
  logic [BYTE_BITS-1:0]      out_abs_error;
  logic [COUNT_BITS_DEF-1:0] out_sample_count;
  logic [COUNT_BITS_DEF-1:0] out_differing_count;
  logic [BYTE_BITS-1:0]      out_largest_error;
  logic [ABS_BITS-1:0]       out_abs_error_total;
  logic [SQ_BITS-1:0]        out_sq_error_total;
  logic [COUNT_BITS_DEF-1:0] out_bin_count;
  logic                      psel            = 1'b0;
  logic                      penable         = 1'b0;
  logic                      pwrite          = 1'b0;
  logic [PADDR_BITS-1:0]     paddr           = '0;
  logic [APB_DATA_BITS-1:0]  pwdata          = '0;
  logic [APB_DATA_BITS-1:0]  prdata;
  logic                      pready;

  // When set, the request side sends back to back with no gaps.
  logic                      steady          = 1'b0;
  int                        idle_cycles     = 0;
  plane_error_tracker        tracker;

  yuv_plane_error_metrics_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_action           (in_action),
    .in_ref_byte         (in_ref_byte),
    .in_dist_byte        (in_dist_byte),
    .in_plane_select     (in_plane_select),
    .in_bin_index        (in_bin_index),
    .empty               (empty),
    .pop                 (pop),
    .out_sample_plane    (out_sample_plane),
    .out_abs_error       (out_abs_error),
    .out_sample_count    (out_sample_count),
    .out_differing_count (out_differing_count),
    .out_largest_error   (out_largest_error),
    .out_abs_error_total (out_abs_error_total),
    .out_sq_error_total  (out_sq_error_total),
    .out_bin_count       (out_bin_count),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one, so that
  // stalls land on every stage of the pipeline and on the output queue.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drive one request and hold it until the block takes it. The tracker
  // learns about the request at the very edge that accepts it. Every path
  // through here makes at most one assignment to push per time step.
  task automatic send_request(stats_req_t r);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push            <= 1'b1;
    in_action       <= r.action;
    in_ref_byte     <= r.ref_byte;
    in_dist_byte    <= r.dist_byte;
    in_plane_select <= r.plane_select;
    in_bin_index    <= r.bin_index;
    do @(posedge clk); while (full);
    tracker.note_request(r);
  endtask

  task automatic issue(logic [ACTION_BITS-1:0] action, logic [BYTE_BITS-1:0] ref_b,
                       logic [BYTE_BITS-1:0] dist_b, logic [SET_BITS-1:0] sel,
                       logic [BIN_BITS-1:0] bin);
    stats_req_t r;
    r.action       = action;
    r.ref_byte     = ref_b;
    r.dist_byte    = dist_b;
    r.plane_select = sel;
    r.bin_index    = bin;
    send_request(r);
  endtask

  // Random traffic. Most requests accumulate, with the distorted byte often
  // equal or close to the reference so that the low histogram bins fill up;
  // reads favor those bins. Fields that an action ignores carry random noise.
  task automatic send_random_request();
    stats_req_t r;
    int         roll;
    r.ref_byte     = 8'($urandom);
    r.dist_byte    = 8'($urandom);
    r.plane_select = 2'($urandom);
    r.bin_index    = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 72) begin
      r.action = ACT_ACCUM;
      case ($urandom_range(0, 3))
        0:       r.dist_byte = r.ref_byte;
        1, 2:    r.dist_byte = r.ref_byte + 8'($urandom_range(0, 6)) - 8'd3;
        default: ;
      endcase
    end else if (roll < 95) begin
      r.action = ACT_READ;
      if ($urandom_range(0, 1) == 1) r.bin_index = 8'($urandom_range(0, 4));
    end else if (roll < 97) begin
      r.action = ACT_CLEAR;
    end else begin
      r.action = ACT_UNUSED;
    end
    send_request(r);
  endtask

  // Stop sending and wait until every expected result has been popped, then
  // let the pipeline settle before touching the registers.
  task automatic wait_idle();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write of one register followed by a read back. Bits above the
  // register's width carry random junk, which the block must drop.
  task automatic program_register(logic [1:0] index, logic [CFG_BITS-1:0] field);
    logic [APB_DATA_BITS-1:0] mask;
    logic [APB_DATA_BITS-1:0] value;
    mask  = (index == REG_CHROMA_ABSENT) ? 32'h1 : 32'h3FFF;
    value = ($urandom & ~mask) | (32'(field) & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(index, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (value & mask)) begin
      $error("register %0d read back: expected %0d, got %0d", index, value & mask, prdata);
      tracker.fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h, logic luma_only);
    wait_idle();
    program_register(REG_FRAME_WIDTH, w);
    program_register(REG_FRAME_HEIGHT, h);
    program_register(REG_CHROMA_ABSENT, {13'd0, luma_only});
  endtask

  // Result side: pop in runs of random length separated by random gaps.
  initial begin : pop_pacing
    int run;
    int gap;
    forever begin
      run = $urandom_range(1, 40);
      gap = pick_gap();
      pop <= 1'b1;
      repeat (run) @(posedge clk);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Every result accepted at this edge goes to the tracker. Outputs are read
  // at the edge, so they hold the values from just before it.
  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      tracker.check_result({out_sample_plane, out_abs_error, out_sample_count,
                            out_differing_count, out_largest_error, out_abs_error_total,
                            out_sq_error_total, out_bin_count});
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting at the reset geometry of 1920x1080 4:2:0.
    // Largest error in both directions, a zero error, and an error of one.
    issue(ACT_ACCUM, 8'd0, 8'd255, SET_ALL, 8'd0);
    issue(ACT_ACCUM, 8'd255, 8'd0, PLANE_V, 8'd255);
    issue(ACT_ACCUM, 8'd0, 8'd0, PLANE_U, 8'd0);
    issue(ACT_ACCUM, 8'd128, 8'd127, PLANE_Y, 8'd1);
    // Read every set, hitting the top and bottom histogram bins.
    issue(ACT_READ, 8'd255, 8'd255, PLANE_Y, 8'd255);
    issue(ACT_READ, 8'd0, 8'd0, SET_ALL, 8'd0);
    issue(ACT_READ, 8'd0, 8'd0, PLANE_U, 8'd1);
    issue(ACT_READ, 8'd0, 8'd0, PLANE_V, 8'd128);
    // The unused action must leave everything alone and return zeros.
    issue(ACT_UNUSED, 8'd255, 8'd255, SET_ALL, 8'd255);
    issue(ACT_READ, 8'd0, 8'd0, SET_ALL, 8'd255);
    // Clear, then confirm the stores are empty.
    issue(ACT_CLEAR, 8'd255, 8'd1, SET_ALL, 8'd255);
    issue(ACT_READ, 8'd0, 8'd0, SET_ALL, 8'd255);

    // A zero width and height act as 1x1: a one-byte frame, all luma.
    set_frame(14'd0, 14'd0, 1'b0);
    issue(ACT_ACCUM, 8'd17, 8'd3, PLANE_V, 8'd0);
    issue(ACT_ACCUM, 8'd3, 8'd17, PLANE_V, 8'd0);
    issue(ACT_READ, 8'd0, 8'd0, PLANE_U, 8'd14);

    // A 3x2 frame has six luma bytes and one byte in each chroma plane.
    // Nine bytes walk through Y, U, V and wrap into the next frame.
    set_frame(14'd3, 14'd2, 1'b0);
    repeat (9) issue(ACT_ACCUM, 8'($urandom), 8'($urandom), PLANE_Y, 8'd0);
    issue(ACT_READ, 8'd0, 8'd0, PLANE_U, 8'd0);
    issue(ACT_READ, 8'd0, 8'd0, PLANE_V, 8'd0);

    // Shrinking to a 1x1 luma-only frame leaves the position past the end,
    // so it must restart at zero. Chroma reads return nothing new.
    set_frame(14'd1, 14'd1, 1'b1);
    issue(ACT_ACCUM, 8'd200, 8'd100, SET_ALL, 8'd0);
    issue(ACT_READ, 8'd0, 8'd0, PLANE_V, 8'd0);

    // Random part under a series of geometries: a few fixed extremes, the
    // rest small frames so that all three planes turn over often.
    for (phase = 0; phase < 12; phase++) begin
      case (phase)
        0:       set_frame(14'd4, 14'd4, 1'b0);
        1:       set_frame(14'd0, 14'd0, 1'b0);
        2:       set_frame(14'd16383, 14'd16383, 1'b1);
        3:       set_frame(14'd8192, 14'd8192, 1'b0);
        4:       set_frame(14'd8193, 14'd1, 1'b0);
        5:       set_frame(14'd1, 14'd1, 1'b1);
        default: set_frame(14'($urandom_range(1, 9)), 14'($urandom_range(1, 9)),
                           ($urandom_range(0, 9) < 3));
      endcase
      steady = (phase % 3 == 2);
      repeat (102) send_random_request();
    end

    // Drain, let any stray result show up, then report.
    wait_idle();
    repeat (20) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
